// ===== src/three_phase_step_commutator_macros.svh =====
// Assertion macros shared by the commutator checker.
`ifndef THREE_PHASE_STEP_COMMUTATOR_MACROS_SVH
`define THREE_PHASE_STEP_COMMUTATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TPSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tpsc_pkg.sv =====
// Types, request codes and the duty table of the three-phase step commutator.
package tpsc_pkg;

  localparam logic [1:0]  REQ_MOVE     = 2'd0;
  localparam logic [1:0]  REQ_TICK     = 2'd1;
  localparam logic [1:0]  REQ_ZERO     = 2'd2;
  localparam logic [3:0]  LAST_STEP    = 4'd11;
  localparam logic [15:0] PERIOD_RESET = 16'd512;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] move_amount;
  } tpsc_in_t;

  typedef struct packed {
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [7:0] duty_c;
    logic       drive_enable;
    logic [3:0] step_index;
    logic       stepping;
    logic       step_taken;
  } tpsc_out_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } tpsc_duty_t;

  // Sine-like duty triple for each of the twelve electrical steps.
  function automatic tpsc_duty_t duty_lookup(input logic [3:0] idx);
    tpsc_duty_t d;
    case (idx)
      4'd0:    d = '{8'd127, 8'd238, 8'd18};
      4'd1:    d = '{8'd191, 8'd191, 8'd1};
      4'd2:    d = '{8'd238, 8'd127, 8'd18};
      4'd3:    d = '{8'd255, 8'd63,  8'd63};
      4'd4:    d = '{8'd238, 8'd18,  8'd127};
      4'd5:    d = '{8'd191, 8'd1,   8'd191};
      4'd6:    d = '{8'd127, 8'd18,  8'd238};
      4'd7:    d = '{8'd63,  8'd63,  8'd255};
      4'd8:    d = '{8'd18,  8'd127, 8'd238};
      4'd9:    d = '{8'd1,   8'd191, 8'd191};
      4'd10:   d = '{8'd18,  8'd238, 8'd127};
      4'd11:   d = '{8'd63,  8'd255, 8'd63};
      default: d = '{8'd0,   8'd0,   8'd0};
    endcase
    return d;
  endfunction

endpackage

// ===== src/tpsc_in_stage.sv =====
// Input register: holds one accepted request item until the core takes it.
module tpsc_in_stage
  import tpsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  tpsc_in_t req,
  input  logic     take,
  output logic     held_valid,
  output tpsc_in_t held
);

  // Accept when empty or when the held item moves on this cycle.
  assign req_ready = !held_valid || take;

  // Track occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  // Capture payload.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held <= req;
    end
  end

endmodule

// ===== src/tpsc_core.sv =====
// Commutation state and its single-pass update for one request item.
module tpsc_core
  import tpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  tpsc_in_t    item,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output tpsc_out_t   result
);

  logic [15:0] step_period;
  logic [3:0]  phase_step,  phase_step_next;
  logic [15:0] steps_left,  steps_left_next;
  logic [15:0] countdown,   countdown_next;
  logic        running,     running_next;
  logic        enables_on,  enables_on_next;
  tpsc_duty_t  duty,        duty_next;
  logic        taken;
  logic [3:0]  s;

  // Work out the state after this item.
  always_comb begin
    phase_step_next = phase_step;
    steps_left_next = steps_left;
    countdown_next  = countdown;
    running_next    = running;
    enables_on_next = enables_on;
    duty_next       = duty;
    taken           = 1'b0;
    s               = phase_step;
    case (item.req_type)
      REQ_MOVE: begin
        steps_left_next = item.move_amount;
        enables_on_next = 1'b1;
        countdown_next  = step_period;
        running_next    = 1'b1;
      end
      REQ_TICK: begin
        if (running) begin
          if (countdown <= 16'd1) begin
            if (steps_left == 16'd0) begin
              // Nothing left: stop and release the bridge.
              duty_next       = '0;
              enables_on_next = 1'b0;
              running_next    = 1'b0;
            end else begin
              if (steps_left[15]) begin
                steps_left_next = steps_left + 16'd1;
                s = (phase_step >= LAST_STEP) ? 4'd0 : phase_step + 4'd1;
              end else begin
                steps_left_next = steps_left - 16'd1;
                s = (phase_step == 4'd0 || phase_step > LAST_STEP) ?
                    LAST_STEP : phase_step - 4'd1;
              end
              phase_step_next = s;
              duty_next       = duty_lookup(s);
              countdown_next  = step_period;
              taken           = 1'b1;
            end
          end else begin
            countdown_next = countdown - 16'd1;
          end
        end
      end
      REQ_ZERO: begin
        duty_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Commit state when an item passes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      steps_left <= '0;
      countdown  <= '0;
      running    <= 1'b0;
      enables_on <= 1'b0;
      duty       <= '0;
    end else if (go) begin
      phase_step <= phase_step_next;
      steps_left <= steps_left_next;
      countdown  <= countdown_next;
      running    <= running_next;
      enables_on <= enables_on_next;
      duty       <= duty_next;
    end
  end

  // Hold the step period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= PERIOD_RESET;
    end else if (cfg_write) begin
      step_period <= cfg_data;
    end
  end

  // Report the post-item state.
  always_comb begin
    result.duty_a       = duty_next.a;
    result.duty_b       = duty_next.b;
    result.duty_c       = duty_next.c;
    result.drive_enable = enables_on_next;
    result.step_index   = phase_step_next;
    result.stepping     = running_next;
    result.step_taken   = taken;
  end

endmodule

// ===== src/tpsc_out_stage.sv =====
// Result register: holds one result item until the consumer takes it.
module tpsc_out_stage
  import tpsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  tpsc_out_t result,
  output logic      slot_free,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output tpsc_out_t rsp
);

  // Free when empty or drained this cycle.
  assign slot_free = !rsp_valid || rsp_ready;

  // Track occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (slot_free) begin
      rsp_valid <= load;
    end
  end

  // Capture payload.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= result;
    end
  end

endmodule

// ===== src/three_phase_step_commutator.sv =====
// Three-phase 12-step commutator: an accepted item goes through the input register and
// then the result register, one item per cycle sustained while rsp_ready does not stall.
// The core update is a single pass of compare, add and a 12-entry table read between
// the input and result registers. Synchronous active-high reset clears state, step_period
// to 512. cfg_ready is always high.
module three_phase_step_commutator
  import tpsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  tpsc_in_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output tpsc_out_t   rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic      held_valid;
  tpsc_in_t  held;
  logic      slot_free;
  logic      take;
  tpsc_out_t result;

  assign cfg_ready = 1'b1;
  // Move the held item when the result register can take it.
  assign take = held_valid && slot_free;

  tpsc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  tpsc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (take),
    .item      (held),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  tpsc_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .result    (result),
    .slot_free (slot_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== src/tpsc_checker.sv =====
// Port-level checker for the commutator and its bind.
`include "three_phase_step_commutator_macros.svh"

module tpsc_checker
  import tpsc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input tpsc_in_t    req,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input tpsc_out_t   rsp,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  // A stalled result item keeps its payload.
  `TPSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

  // Stepping only runs with the bridge enabled.
  `TPSC_ASSERT_NOW(a_run_enabled, rsp_valid && rsp.stepping, rsp.drive_enable, "stepping without enable")

  // A step lands on a legal index with a live table entry.
  `TPSC_ASSERT_NOW(a_step_sane, rsp_valid && rsp.step_taken, rsp.stepping && rsp.step_index <= LAST_STEP && rsp.duty_b != 8'd0, "bad step result")

  // Released bridge implies zero duties.
  `TPSC_ASSERT_NOW(a_idle_zero, rsp_valid && !rsp.drive_enable, rsp.duty_a == 8'd0 && rsp.duty_b == 8'd0 && rsp.duty_c == 8'd0, "duty left on while disabled")

endmodule

bind three_phase_step_commutator tpsc_checker u_tpsc_checker (.*);

// ===== bench/tb_three_phase_step_commutator.sv =====
// Self-checking bench for the three-phase step commutator: directed rows, then random traffic.
module tb_three_phase_step_commutator;
  import tpsc_pkg::*;

  // Request code that the block leaves without effect
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SEG_ITEMS = 190;

  // Duty triples {a, b, c} per electrical step, step 0 in the low bits
  localparam logic [12*24-1:0] SINE_STEPS = {
    {8'd63,  8'd255, 8'd63},  {8'd18,  8'd238, 8'd127},
    {8'd1,   8'd191, 8'd191}, {8'd18,  8'd127, 8'd238},
    {8'd63,  8'd63,  8'd255}, {8'd127, 8'd18,  8'd238},
    {8'd191, 8'd1,   8'd191}, {8'd238, 8'd18,  8'd127},
    {8'd255, 8'd63,  8'd63},  {8'd238, 8'd127, 8'd18},
    {8'd191, 8'd191, 8'd1},   {8'd127, 8'd238, 8'd18}
  };

  typedef struct {
    bit          is_cfg;
    tpsc_in_t    item;
    logic [15:0] period;
    bit          typed;
    tpsc_out_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  tpsc_in_t    req;
  logic        rsp_valid;
  logic        rsp_ready;
  tpsc_out_t   rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Predicted commutator state
  logic [15:0] cfg_period;
  logic [3:0]  st_phase;
  logic [15:0] st_left;
  logic [15:0] st_count;
  logic        st_run;
  logic        st_enable;
  logic [23:0] st_duty;

  tpsc_out_t   drive_expected[$];
  tpsc_out_t   oldest;
  stim_row_t   plan[$];
  logic [15:0] seg_periods[8];
  bit          quiet;
  int          mismatch_count;
  int          items_sent;
  int          results_seen;
  int          steps_seen;
  int          stops_seen;
  int          cycles;

  three_phase_step_commutator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the predicted state by one item and return the result it causes
  function automatic tpsc_out_t predict_drive(input tpsc_in_t item);
    tpsc_out_t o;
    logic      taken;
    int        nxt;
    taken = 1'b0;
    case (item.req_type)
      REQ_MOVE: begin
        st_left   = item.move_amount;
        st_enable = 1'b1;
        st_count  = cfg_period;
        st_run    = 1'b1;
      end
      REQ_TICK: begin
        if (st_run) begin
          if (st_count <= 16'd1) begin
            if (st_left == 16'd0) begin
              // Out of steps: release the bridge
              st_duty   = '0;
              st_enable = 1'b0;
              st_run    = 1'b0;
            end else begin
              // Negative count walks forward, positive walks backward
              if (st_left[15]) begin
                st_left = st_left + 16'd1;
                nxt = (st_phase >= LAST_STEP) ? 0 : st_phase + 1;
              end else begin
                st_left = st_left - 16'd1;
                nxt = (st_phase == 4'd0 || st_phase > LAST_STEP) ? LAST_STEP : st_phase - 1;
              end
              st_phase = 4'(nxt);
              st_duty  = SINE_STEPS[nxt*24 +: 24];
              st_count = cfg_period;
              taken    = 1'b1;
            end
          end else begin
            st_count = st_count - 16'd1;
          end
        end
      end
      REQ_ZERO: st_duty = '0;
      default: ;
    endcase
    o = {st_duty, st_enable, st_phase, st_run, taken};
    return o;
  endfunction

  function automatic stim_row_t mk_row(input bit is_cfg, input logic [1:0] rt,
                                       input logic [15:0] v, input bit typed,
                                       input tpsc_out_t want);
    stim_row_t r;
    r.is_cfg = is_cfg;
    r.item   = {rt, v};
    r.period = v;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Present one item, hold it until accepted, and record its expected result
  task automatic send_item(input tpsc_in_t v, input bit typed, input tpsc_out_t want);
    tpsc_out_t exp_out;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= v;
    do @(posedge clk); while (!req_ready);
    exp_out = predict_drive(v);
    drive_expected.push_back(typed ? want : exp_out);
    items_sent++;
    @(negedge clk);
  endtask

  // Drain outstanding results, then write the step period
  task automatic write_period(input logic [15:0] val);
    req_valid <= 1'b0;
    while (drive_expected.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_period = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (drive_expected.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, rsp);
        mismatch_count++;
      end else begin
        oldest = drive_expected.pop_front();
        check_field("duty_a", oldest.duty_a, rsp.duty_a);
        check_field("duty_b", oldest.duty_b, rsp.duty_b);
        check_field("duty_c", oldest.duty_c, rsp.duty_c);
        check_field("drive_enable", 8'(oldest.drive_enable), 8'(rsp.drive_enable));
        check_field("step_index", 8'(oldest.step_index), 8'(rsp.step_index));
        check_field("stepping", 8'(oldest.stepping), 8'(rsp.stepping));
        check_field("step_taken", 8'(oldest.step_taken), 8'(rsp.step_taken));
        results_seen++;
        if (rsp.step_taken) steps_seen++;
        if (oldest.stepping == 1'b0 && oldest.step_index != 4'd0) stops_seen++;
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    rsp_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        rsp_ready <= 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, drive_expected.size());
      $display("three_phase_step_commutator verification failed");
      $finish;
    end
  end

  initial begin
    tpsc_in_t  rnd;
    int        pick;
    int        directed;
    tpsc_out_t none;

    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    quiet          = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    steps_seen     = 0;
    stops_seen     = 0;
    cycles         = 0;
    none           = '0;

    // Reset state of the prediction
    cfg_period = PERIOD_RESET;
    st_phase   = '0;
    st_left    = '0;
    st_count   = '0;
    st_run     = 1'b0;
    st_enable  = 1'b0;
    st_duty    = '0;

    // Directed rows: reset state, wrap at both ends, extreme counts and periods
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 1, none));
    plan.push_back(mk_row(0, REQ_UNUSED, 16'h7FFF, 1, none));
    plan.push_back(mk_row(0, REQ_ZERO,   16'hFFFF, 1, none));
    plan.push_back(mk_row(0, REQ_MOVE,   16'h0000, 1,
                          {8'd0, 8'd0, 8'd0, 1'b1, 4'd0, 1'b1, 1'b0}));
    plan.push_back(mk_row(0, REQ_ZERO,   16'h0000, 1,
                          {8'd0, 8'd0, 8'd0, 1'b1, 4'd0, 1'b1, 1'b0}));
    plan.push_back(mk_row(1, REQ_MOVE,   16'd0,    0, none));
    plan.push_back(mk_row(0, REQ_MOVE,   16'h0001, 1,
                          {8'd0, 8'd0, 8'd0, 1'b1, 4'd0, 1'b1, 1'b0}));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 1,
                          {8'd63, 8'd255, 8'd63, 1'b1, 4'd11, 1'b1, 1'b1}));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 1,
                          {8'd0, 8'd0, 8'd0, 1'b0, 4'd11, 1'b0, 1'b0}));
    plan.push_back(mk_row(0, REQ_MOVE,   16'hFFFE, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_MOVE,   16'h8000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'hFFFF, 0, none));
    plan.push_back(mk_row(0, REQ_ZERO,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_MOVE,   16'h7FFF, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(1, REQ_MOVE,   16'd1,    0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(1, REQ_MOVE,   16'hFFFF, 0, none));
    plan.push_back(mk_row(0, REQ_MOVE,   16'hAAAA, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h5555, 0, none));
    plan.push_back(mk_row(0, REQ_UNUSED, 16'h5555, 0, none));
    plan.push_back(mk_row(1, REQ_MOVE,   16'd2,    0, none));
    plan.push_back(mk_row(0, REQ_MOVE,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));
    plan.push_back(mk_row(0, REQ_TICK,   16'h0000, 0, none));

    // Hold reset, then release on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_period(plan[i].period);
      else send_item(plan[i].item, plan[i].typed, plan[i].want);
    end
    directed = items_sent;

    // Random segments, one step period each; the third and the last run without idling
    seg_periods[0] = 16'd0;
    seg_periods[1] = 16'd1;
    seg_periods[2] = 16'd3;
    seg_periods[3] = 16'hFFFF;
    seg_periods[4] = 16'd2;
    seg_periods[5] = 16'($urandom_range(4, 15));
    seg_periods[6] = 16'($urandom_range(0, 65535));
    seg_periods[7] = 16'd1;
    for (int seg = 0; seg < 8; seg++) begin
      write_period(seg_periods[seg]);
      quiet = (seg == 2 || seg == 7);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        rnd.move_amount = 16'($urandom_range(0, 65535));
        if (pick < 8) begin
          rnd.req_type    = REQ_MOVE;
          rnd.move_amount = 16'(int'($urandom_range(0, 24)) - 12);
        end else if (pick < 10) begin
          rnd.req_type = REQ_MOVE;
        end else if (pick < 12) begin
          rnd.req_type = REQ_ZERO;
        end else if (pick < 14) begin
          rnd.req_type = REQ_UNUSED;
        end else begin
          rnd.req_type = REQ_TICK;
        end
        send_item(rnd, 1'b0, none);
      end
    end

    // Drain and let any stray result show up
    req_valid <= 1'b0;
    while (drive_expected.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("sent %0d items (%0d directed) over periods 0 to 65535 with random stalls",
             items_sent, directed);
    $display("checked %0d results, %0d step advances, %0d mismatches",
             results_seen, steps_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("three_phase_step_commutator verification clean");
    end else begin
      $display("three_phase_step_commutator verification failed");
    end
    $finish;
  end

endmodule
